>>> rtl/core/assert_macros.svh
// assertion macros for the marker filter checker
// depends on nothing; included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define SMF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("marker filter check failed");

// next-cycle implication, off while reset is low
`define SMF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("marker filter check failed");

// holds at every edge, reset included
`define SMF_ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("marker filter check failed");

`endif

>>> rtl/core/smf_pkg.sv
// shared types and constants of the sync and reset marker filter
// used by the front, the executor and the top level; depends on nothing
`default_nettype none

package smf_pkg;

    // default marker capacity in bytes
    localparam int MARKER_BYTES_DEF = 16;
    // bytes carried by one pair of marker registers
    localparam int REG_BYTES = 16;
    // queue depths
    localparam int IN_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH = 4;

    // request codes on req_type
    localparam logic [1:0] REQ_DATA    = 2'd0;
    localparam logic [1:0] REQ_FLUSH   = 2'd1;
    localparam logic [1:0] REQ_CONNECT = 2'd2;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_READY_LOW  = 3'd0,
        CFG_READY_HIGH = 3'd1,
        CFG_READY_LEN  = 3'd2,
        CFG_RESET_LOW  = 3'd3,
        CFG_RESET_HIGH = 3'd4,
        CFG_RESET_LEN  = 3'd5
    } cfg_idx_t;

    // classified operation handed from front to executor
    typedef enum logic [1:0] {
        OP_DATA    = 2'd0,
        OP_FLUSH   = 2'd1,
        OP_CONNECT = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } op_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] out_byte;
        logic       last;
    } res_item_t;

    // marker settings seen by the executor
    typedef struct packed {
        logic [8*REG_BYTES-1:0] ready_bytes;
        logic [4:0]             ready_len;
        logic [8*REG_BYTES-1:0] reset_bytes;
        logic [4:0]             reset_len;
    } mk_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/smf_fifo.sv
// small first-in first-out queue built from registers
// used by the front and the top level; depends on nothing
`default_nettype none

module smf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/smf_front.sv
// front of the marker filter: takes requests, decodes them into operations
// and queues them for the executor; depends on smf_pkg and smf_fifo
`default_nettype none

module smf_front
    import smf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic [7:0] data_byte,
    output logic       op_valid,
    output op_item_t   op_item,
    input  logic       op_pop
);

    op_item_t                   enq_item;
    logic                       keep;
    logic                       q_empty;
    logic [$bits(op_item_t)-1:0] q_rdata;

    // unused request code is taken and dropped
    always_comb
    begin
        keep        = 1'b1;
        enq_item.op = OP_DATA;
        case (req_type)
            REQ_DATA:    enq_item.op = OP_DATA;
            REQ_FLUSH:   enq_item.op = OP_FLUSH;
            REQ_CONNECT: enq_item.op = OP_CONNECT;
            default:     keep = 1'b0;
        endcase
        enq_item.data_byte = data_byte;
    end

    smf_fifo #(
        .WIDTH ($bits(op_item_t)),
        .DEPTH (IN_Q_DEPTH)
    ) u_op_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && keep),
        .wr_data (enq_item),
        .full    (full),
        .rd_en   (op_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    assign op_valid = !q_empty;
    assign op_item  = op_item_t'(q_rdata);

endmodule

`default_nettype wire

>>> rtl/core/smf_exec.sv
// executor of the marker filter: holds the byte window, matches markers at its
// head one step a cycle unless stalled, produces results; depends on smf_pkg
`default_nettype none

module smf_exec
    import smf_pkg::*;
#(
    parameter int MARKER_BYTES = MARKER_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  mk_cfg_t   cfg,
    input  logic      op_valid,
    input  op_item_t  op_item,
    output logic      op_pop,
    input  logic      res_full,
    output logic      res_push,
    output res_item_t res_item
);

    localparam int MK    = (MARKER_BYTES < REG_BYTES) ? MARKER_BYTES : REG_BYTES;
    localparam int CNT_W = $clog2(MARKER_BYTES + 1);
    localparam int LEN_W = $clog2(MK + 1);

    logic [7:0]       hold_reg [MARKER_BYTES];
    logic [7:0]       hold_next [MARKER_BYTES];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             await_reg, await_next;
    logic             active_reg, active_next;
    logic             flush_reg, flush_next;
    logic             pend_valid_reg, pend_valid_next;
    logic             pend_final_reg, pend_final_next;
    logic             pend_kind_reg, pend_kind_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;

    logic [4:0]       lenr_clamp, lens_clamp;
    logic [LEN_W-1:0] lenr, lens, len_sel;
    logic [7:0]       mk_sel [MK];
    logic [7:0]       view [MARKER_BYTES];
    logic [CNT_W-1:0] vn;
    logic [MK-1:0]    eq;
    logic             pmatch;
    logic             aw;
    logic             go, start, cur, append;
    op_t              cur_op;
    logic             res_valid, res_kind;
    logic [7:0]       res_byte;
    logic [LEN_W-1:0] s_amt;
    logic             clr, item_end;
    logic             pend_push;

    // lengths beyond capacity act as capacity
    assign lenr_clamp = (cfg.ready_len > 5'(MK)) ? 5'(MK) : cfg.ready_len;
    assign lens_clamp = (cfg.reset_len > 5'(MK)) ? 5'(MK) : cfg.reset_len;
    assign lenr       = lenr_clamp[LEN_W-1:0];
    assign lens       = lens_clamp[LEN_W-1:0];

    // an empty ready marker ends the wait on the next data byte
    assign aw      = await_reg && (lenr != '0);
    assign len_sel = aw ? lenr : lens;

    assign go     = !res_full;
    assign start  = !active_reg && op_valid && go;
    assign cur    = go && (active_reg || op_valid);
    assign cur_op = active_reg ? (flush_reg ? OP_FLUSH : OP_DATA) : op_item.op;
    assign append = start && (op_item.op == OP_DATA);
    assign op_pop = start;

    always_comb
    begin
        for (int i = 0; i < MK; i++)
        begin
            mk_sel[i] = aw ? cfg.ready_bytes[8*i +: 8] : cfg.reset_bytes[8*i +: 8];
        end
    end

    // window as seen this cycle: new byte appended when a data item starts
    always_comb
    begin
        for (int i = 0; i < MARKER_BYTES; i++)
        begin
            view[i] = (append && (CNT_W'(i) == cnt_reg)) ? op_item.data_byte : hold_reg[i];
        end
        vn = append ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    // head of window against marker over min(window, marker) bytes
    always_comb
    begin
        for (int i = 0; i < MK; i++)
        begin
            eq[i] = (view[i] == mk_sel[i]) || (CNT_W'(i) >= vn) || (LEN_W'(i) >= len_sel);
        end
        pmatch = &eq;
    end

    always_comb
    begin
        res_valid  = 1'b0;
        res_kind   = KIND_BYTE;
        res_byte   = view[0];
        s_amt      = '0;
        clr        = 1'b0;
        item_end   = 1'b0;
        await_next = await_reg;
        if (cur)
        begin
            case (cur_op)
                OP_CONNECT:
                begin
                    clr        = 1'b1;
                    await_next = 1'b1;
                    item_end   = 1'b1;
                end
                OP_FLUSH:
                begin
                    if (await_reg)
                    begin
                        clr        = 1'b1;
                        await_next = 1'b0;
                        item_end   = 1'b1;
                    end
                    else if (vn == '0)
                    begin
                        item_end = 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        s_amt     = LEN_W'(1);
                        item_end  = (vn == CNT_W'(1));
                    end
                end
                OP_DATA:
                begin
                    await_next = aw;
                    if (aw)
                    begin
                        if (pmatch && (vn >= CNT_W'(len_sel)))
                        begin
                            s_amt      = len_sel;
                            await_next = 1'b0;
                            item_end   = (vn == CNT_W'(len_sel));
                        end
                        else if (vn < CNT_W'(len_sel))
                        begin
                            item_end = 1'b1;
                        end
                        else
                        begin
                            // discard the oldest byte while waiting
                            s_amt    = LEN_W'(1);
                            item_end = ((vn - CNT_W'(1)) < CNT_W'(len_sel));
                        end
                    end
                    else if (len_sel == '0)
                    begin
                        if (vn == '0)
                        begin
                            item_end = 1'b1;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            s_amt     = LEN_W'(1);
                            item_end  = (vn == CNT_W'(1));
                        end
                    end
                    else if (pmatch && (vn >= CNT_W'(len_sel)))
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_EVENT;
                        res_byte  = '0;
                        s_amt     = len_sel;
                        item_end  = (vn == CNT_W'(len_sel));
                    end
                    else if (pmatch)
                    begin
                        // window is a marker prefix, hold it
                        item_end = 1'b1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                        s_amt     = LEN_W'(1);
                        item_end  = (vn == CNT_W'(1));
                    end
                end
                default:
                begin
                    item_end = 1'b1;
                end
            endcase
        end
    end

    // window shift by the step size
    always_comb
    begin
        for (int i = 0; i < MARKER_BYTES; i++)
        begin
            hold_next[i] = view[i];
            for (int k = 1; (k <= MK) && (i + k < MARKER_BYTES); k++)
            begin
                if (s_amt == LEN_W'(k))
                begin
                    hold_next[i] = view[i + k];
                end
            end
        end
    end

    assign cnt_next    = clr ? '0 : vn - CNT_W'(s_amt);
    assign active_next = cur ? !item_end : active_reg;
    assign flush_next  = start ? (op_item.op == OP_FLUSH) : flush_reg;

    // one result waits in pend so that the final one can be marked last
    assign pend_push = go && pend_valid_reg && (pend_final_reg || res_valid || item_end);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_final_next = pend_final_reg;
        pend_kind_next  = pend_kind_reg;
        pend_byte_next  = pend_byte_reg;
        if (res_valid)
        begin
            pend_valid_next = 1'b1;
            pend_final_next = item_end;
            pend_kind_next  = res_kind;
            pend_byte_next  = res_byte;
        end
        else if (pend_push)
        begin
            pend_valid_next = 1'b0;
        end
    end

    assign res_push             = pend_push;
    assign res_item.result_kind = pend_kind_reg;
    assign res_item.out_byte    = pend_byte_reg;
    assign res_item.last        = pend_final_reg || (item_end && !res_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            await_reg      <= 1'b0;
            active_reg     <= 1'b0;
            flush_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_final_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            await_reg      <= await_next;
            active_reg     <= active_next;
            flush_reg      <= flush_next;
            pend_valid_reg <= pend_valid_next;
            pend_final_reg <= pend_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg      <= hold_next;
        pend_kind_reg <= pend_kind_next;
        pend_byte_reg <= pend_byte_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/sync_and_reset_marker_filter_core.sv
// top level of the sync and reset marker filter: configuration registers,
// front, executor and result queue; depends on smf_pkg, smf_front, smf_exec, smf_fifo
`default_nettype none

// Byte-stream filter with two configurable markers of up to sixteen bytes.
// Requests enter through a queue port (push/full): a data byte, an end-of-stream
// flush, or a connect. After a connect every byte is dropped up to and including
// the first ready marker; after that bytes pass through, each reset marker is
// removed and a reset event result takes its place. Bytes that may still start a
// reset marker are held back until a mismatch releases them or a flush emits
// them (a flush while still waiting for ready discards them). Results leave
// through a queue port (empty/pop), each with last set on the final result of
// its request. Markers are written through the cfg port (always ready); the user
// must write them only while the block is idle; the block does not enforce it.
// The front decodes and queues requests and drops the unused request code; the
// executor works on the byte window one step per cycle. A step emits one byte,
// emits one reset event, takes a ready match or discards one byte while waiting
// for ready; a request with nothing left after such a step ends in it, and one
// that leaves bytes held takes a further step finding that they start a marker,
// unless that look is its only step. Connects, flushes with nothing to emit, and
// bytes that pass, complete a marker or are held end in their first step, so
// ordinary traffic runs at one request per cycle; a request that emits several
// results takes a step for each, plus that look if bytes stay held. Results are
// registered in pend, then queued; a full result queue stalls the executor.
module sync_and_reset_marker_filter_core
    import smf_pkg::*;
#(
    parameter int MARKER_BYTES = MARKER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request queue side
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [7:0]  out_byte,
    output logic        last,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [63:0] ready_low_reg;
    logic [63:0] ready_high_reg;
    logic [4:0]  ready_len_reg;
    logic [63:0] reset_low_reg;
    logic [63:0] reset_high_reg;
    logic [4:0]  reset_len_reg;

    mk_cfg_t     mk_cfg;
    logic        op_valid;
    op_item_t    op_item;
    logic        op_pop;
    logic        res_full;
    logic        res_push;
    res_item_t   res_wr;
    res_item_t   res_rd;
    logic [$bits(res_item_t)-1:0] res_q_rdata;

    // register file takes a write every cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_low_reg  <= '0;
            ready_high_reg <= '0;
            ready_len_reg  <= '0;
            reset_low_reg  <= '0;
            reset_high_reg <= '0;
            reset_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_READY_LOW:  ready_low_reg  <= cfg_data;
                CFG_READY_HIGH: ready_high_reg <= cfg_data;
                CFG_READY_LEN:  ready_len_reg  <= cfg_data[4:0];
                CFG_RESET_LOW:  reset_low_reg  <= cfg_data;
                CFG_RESET_HIGH: reset_high_reg <= cfg_data;
                CFG_RESET_LEN:  reset_len_reg  <= cfg_data[4:0];
                // indexes past the list write nothing
                default: ;
            endcase
        end
    end

    // first marker byte sits in the low byte of the low word
    assign mk_cfg.ready_bytes = {ready_high_reg, ready_low_reg};
    assign mk_cfg.ready_len   = ready_len_reg;
    assign mk_cfg.reset_bytes = {reset_high_reg, reset_low_reg};
    assign mk_cfg.reset_len   = reset_len_reg;

    // decode and queue requests
    smf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .data_byte (data_byte),
        .op_valid  (op_valid),
        .op_item   (op_item),
        .op_pop    (op_pop)
    );

    // byte window, marker matching and result generation
    smf_exec #(
        .MARKER_BYTES (MARKER_BYTES)
    ) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (mk_cfg),
        .op_valid (op_valid),
        .op_item  (op_item),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_item (res_wr)
    );

    // results wait here so the executor keeps going while the consumer stalls, till full
    smf_fifo #(
        .WIDTH ($bits(res_item_t)),
        .DEPTH (OUT_Q_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wr),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q_rdata),
        .empty   (empty)
    );

    assign res_rd      = res_item_t'(res_q_rdata);
    assign result_kind = res_rd.result_kind;
    assign out_byte    = res_rd.out_byte;
    assign last        = res_rd.last;

endmodule

`default_nettype wire

>>> rtl/core/smf_checker.sv
// port-level checks for the marker filter top level and their bind
// depends on assert_macros.svh and sync_and_reset_marker_filter_core
`default_nettype none

`include "assert_macros.svh"

module smf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       result_kind,
    input logic [7:0] out_byte,
    input logic       last
);

    // all result fields as one word
    logic [9:0] res_word;

    assign res_word = {result_kind, out_byte, last};

    // a waiting result that is not taken stays put
    `SMF_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(res_word))

    // reset events carry a zero byte
    `SMF_ASSERT_IMPLY(a_event_zero, clk, rst_n, !empty && result_kind, out_byte == 8'd0)

    // the result queue comes out of reset empty, the request queue not full
    `SMF_ASSERT_ALWAYS(a_rst_idle, clk, !$rose(rst_n) || (empty && !full))

endmodule

bind sync_and_reset_marker_filter_core smf_checker u_smf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .result_kind (result_kind),
    .out_byte    (out_byte),
    .last        (last)
);

`default_nettype wire

>>> tb/sv/smf_filter_checker.sv
// checker for the sync and reset marker filter: watches the request, result and
// configuration channels, predicts the result items and compares them in order
// depends on smf_pkg
`default_nettype none

module smf_filter_checker
    import smf_pkg::*;
#(
    parameter int MARKER_BYTES = MARKER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic        result_kind,
    input  logic [7:0]  out_byte,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          errors,
    output int          results_due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_DEPTH = MARKER_BYTES - 1;
    localparam int WIN_BITS   = 8 * MARKER_BYTES;

    logic [8*REG_BYTES-1:0] ready_pat;
    logic [8*REG_BYTES-1:0] reset_pat;
    logic [4:0]             ready_len_raw;
    logic [4:0]             reset_len_raw;
    logic [WIN_BITS-1:0]    held;
    int                     held_cnt;
    bit                     awaiting_ready;
    res_item_t              results_due[$];

    // lengths above the register or the capacity are clipped
    function automatic int marker_len(input logic [4:0] raw);
        int v;
        v = int'(raw);
        if (v > REG_BYTES) v = REG_BYTES;
        if (v > MARKER_BYTES) v = MARKER_BYTES;
        return v;
    endfunction

    // first position at or after from where the marker fits in the window, or -1
    function automatic int find_marker_at(input logic [WIN_BITS-1:0] win, input int from,
                                          input int n, input logic [8*REG_BYTES-1:0] pat,
                                          input int len);
        int s;
        int j;
        bit hit;
        for (s = from; s + len <= n; s++)
        begin
            hit = 1'b1;
            for (j = 0; j < len; j++)
                if (win[8*(s+j) +: 8] != pat[8*j +: 8]) hit = 1'b0;
            if (hit) return s;
        end
        return -1;
    endfunction

    // longest window tail, shorter than the marker, that equals its head
    function automatic int tail_overlap(input logic [WIN_BITS-1:0] win, input int from,
                                        input int n, input logic [8*REG_BYTES-1:0] pat,
                                        input int len);
        int k;
        int j;
        bit hit;
        k = len - 1;
        if (k > n - from) k = n - from;
        while (k > 0)
        begin
            hit = 1'b1;
            for (j = 0; j < k; j++)
                if (win[8*(n-k+j) +: 8] != pat[8*j +: 8]) hit = 1'b0;
            if (hit) return k;
            k--;
        end
        return 0;
    endfunction

    function automatic void add_result(input logic kind, input logic [7:0] b);
        res_item_t r;
        r.result_kind = kind;
        r.out_byte    = b;
        r.last        = 1'b0;
        results_due.insert(results_due.size(), r);
    endfunction

    // one accepted request: update the filter state and queue its result items
    task automatic filter_item(input logic [1:0] req, input logic [7:0] b);
        logic [WIN_BITS-1:0] win;
        res_item_t           r;
        int                  n;
        int                  start;
        int                  len;
        int                  p;
        int                  keep;
        int                  i;
        int                  first;
        bit                  done;
        first = results_due.size();
        case (req)
            REQ_CONNECT:
            begin
                held_cnt       = 0;
                awaiting_ready = 1'b1;
            end
            REQ_FLUSH:
            begin
                if (!awaiting_ready)
                    for (i = 0; i < held_cnt; i++) add_result(KIND_BYTE, held[8*i +: 8]);
                held_cnt       = 0;
                awaiting_ready = 1'b0;
            end
            REQ_DATA:
            begin
                win = held;
                win[8*held_cnt +: 8] = b;
                n     = held_cnt + 1;
                start = 0;
                done  = 1'b0;
                if (awaiting_ready)
                begin
                    len = marker_len(ready_len_raw);
                    if (len == 0)
                        awaiting_ready = 1'b0;
                    else
                    begin
                        p = find_marker_at(win, 0, n, ready_pat, len);
                        if (p < 0)
                        begin
                            // keep only what may still start the ready marker
                            keep  = (len - 1 < n) ? len - 1 : n;
                            start = n - keep;
                            done  = 1'b1;
                        end
                        else
                        begin
                            start          = p + len;
                            awaiting_ready = 1'b0;
                        end
                    end
                end
                if (!done)
                begin
                    len = marker_len(reset_len_raw);
                    if (len == 0)
                    begin
                        for (i = start; i < n; i++) add_result(KIND_BYTE, win[8*i +: 8]);
                        start = n;
                    end
                    while (len != 0 && !done && start < n)
                    begin
                        p = find_marker_at(win, start, n, reset_pat, len);
                        if (p >= 0)
                        begin
                            for (i = start; i < p; i++) add_result(KIND_BYTE, win[8*i +: 8]);
                            add_result(KIND_EVENT, 8'h00);
                            start = p + len;
                        end
                        else
                        begin
                            keep = tail_overlap(win, start, n, reset_pat, len);
                            for (i = start; i < n - keep; i++)
                                add_result(KIND_BYTE, win[8*i +: 8]);
                            start = n - keep;
                            done  = 1'b1;
                        end
                    end
                end
                if (start > n) start = n;
                held_cnt = n - start;
                if (held_cnt > HOLD_DEPTH) held_cnt = HOLD_DEPTH;
                held = win >> (8 * (n - held_cnt));
            end
            default: ;
        endcase
        if (results_due.size() > first)
        begin
            r = results_due[results_due.size() - 1];
            r.last = 1'b1;
            results_due[results_due.size() - 1] = r;
        end
    endtask

    task automatic check_result();
        res_item_t want;
        if (results_due.size() == 0)
        begin
            $error("unexpected result: result_kind %0d out_byte %02h last %0d",
                   result_kind, out_byte, last);
            errors++;
        end
        else
        begin
            want = results_due.pop_front();
            if (result_kind !== want.result_kind)
            begin
                $error("result_kind mismatch: expected %0d, got %0d",
                       want.result_kind, result_kind);
                errors++;
            end
            if (out_byte !== want.out_byte)
            begin
                $error("out_byte mismatch: expected %02h, got %02h", want.out_byte, out_byte);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0d, got %0d", want.last, last);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_pat      = '0;
            reset_pat      = '0;
            ready_len_raw  = '0;
            reset_len_raw  = '0;
            held           = '0;
            held_cnt       = 0;
            awaiting_ready = 1'b0;
            results_due.delete();
            errors         = 0;
            results_due_count <= 0;
        end
        else
        begin
            // results first, so an item accepted at this edge cannot match them
            if (pop && !empty) check_result();
            if (push && !full) filter_item(req_type, data_byte);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_READY_LOW:  ready_pat[63:0]   = cfg_data;
                    CFG_READY_HIGH: ready_pat[127:64] = cfg_data;
                    CFG_READY_LEN:  ready_len_raw     = cfg_data[4:0];
                    CFG_RESET_LOW:  reset_pat[63:0]   = cfg_data;
                    CFG_RESET_HIGH: reset_pat[127:64] = cfg_data;
                    CFG_RESET_LEN:  reset_len_raw     = cfg_data[4:0];
                    default: ;
                endcase
            end
            results_due_count <= results_due.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// top of the marker filter testbench: clock, reset, request and configuration
// stimulus, result-side stalls and the verdict
// depends on smf_pkg, sync_and_reset_marker_filter_core and smf_filter_checker
`default_nettype none

module testbench;
    import smf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // random items per configuration phase, eight phases
    localparam int PHASES       = 8;
    localparam int PER_PHASE    = 46;
    // cycles to let the block settle once nothing is expected
    localparam int SETTLE_CYCLES = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic [1:0]  req_type  = REQ_DATA;
    logic [7:0]  data_byte = 8'h00;
    logic        pop       = 1'b0;
    logic        cfg_valid = 1'b0;
    cfg_idx_t    cfg_index = CFG_READY_LOW;
    logic [63:0] cfg_data  = 64'd0;
    logic        full;
    logic        empty;
    logic        result_kind;
    logic [7:0]  out_byte;
    logic        last;
    logic        cfg_ready;
    int          errors;
    int          results_due_count;

    // current markers, kept here to build well-formed streams
    logic [127:0] ready_pat;
    logic [127:0] reset_pat;
    int           ready_len;
    int           reset_len;
    logic [7:0]   palette [4];

    int items_sent;
    int burst_left;
    int rx_mode;
    int rx_left;
    int rx_tick;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sync_and_reset_marker_filter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    smf_filter_checker filter_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .req_type          (req_type),
        .data_byte         (data_byte),
        .empty             (empty),
        .pop               (pop),
        .result_kind       (result_kind),
        .out_byte          (out_byte),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .errors            (errors),
        .results_due_count (results_due_count)
    );

    // result side: each stretch picks a stall style; mode zero never stalls
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 3) != 0);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((rx_tick % 7) < 2);
        endcase
    end

    // usable marker length as the block sees it
    function automatic int usable_len(input int raw);
        return (raw > REG_BYTES) ? REG_BYTES : raw;
    endfunction

    // mostly bytes the markers are built from, so matches and near misses are common
    function automatic logic [7:0] stream_byte();
        if ($urandom_range(0, 7) == 0) return 8'($urandom);
        return palette[$urandom_range(0, 3)];
    endfunction

    // marker length spread: empty, single, short, full and out of range
    function automatic int pick_len();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 16;
            3:       return $urandom_range(17, 31);
            default: return $urandom_range(2, 5);
        endcase
    endfunction

    // one request item; push stays high inside a burst, a random gap follows a burst
    task automatic send(input logic [1:0] t, input logic [7:0] b);
        int gap;
        push      <= 1'b1;
        req_type  <= t;
        data_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        if (t != REQ_UNUSED) items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count) send(REQ_DATA, stream_byte());
    endtask

    // marker bytes in order; a broken one is cut short or has one bit flipped
    task automatic send_marker(input logic [127:0] pat, input int raw_len, input bit broken);
        int         len;
        int         cut;
        int         flip;
        int         i;
        logic [7:0] b;
        len  = usable_len(raw_len);
        cut  = len;
        flip = -1;
        if (broken && len > 0)
        begin
            if ($urandom_range(0, 1) != 0) cut = $urandom_range(0, len - 1);
            else flip = $urandom_range(0, len - 1);
        end
        for (i = 0; i < cut; i++)
        begin
            b = pat[8*i +: 8];
            if (i == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
            send(REQ_DATA, b);
        end
    endtask

    // wait until every predicted result has been popped, then let the block settle
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (results_due_count != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg_valid stays high across back-to-back register writes
    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // all six marker registers; only called while the block is idle
    task automatic load_markers(input logic [127:0] rp, input int rl,
                                input logic [127:0] sp, input int sl);
        ready_pat = rp;
        ready_len = rl;
        reset_pat = sp;
        reset_len = sl;
        write_reg(CFG_READY_LOW, rp[63:0]);
        write_reg(CFG_READY_HIGH, rp[127:64]);
        write_reg(CFG_READY_LEN, 64'(rl));
        write_reg(CFG_RESET_LOW, sp[63:0]);
        write_reg(CFG_RESET_HIGH, sp[127:64]);
        write_reg(CFG_RESET_LEN, 64'(sl));
        cfg_valid <= 1'b0;
    endtask

    // markers drawn from a fresh random palette
    task automatic random_markers(input int rl, input int sl);
        logic [127:0] rp;
        logic [127:0] sp;
        int           i;
        for (i = 0; i < 4; i++) palette[i] = 8'($urandom);
        for (i = 0; i < 16; i++)
        begin
            rp[8*i +: 8] = palette[$urandom_range(0, 3)];
            sp[8*i +: 8] = palette[$urandom_range(0, 3)];
        end
        load_markers(rp, rl, sp, sl);
    endtask

    // one random phase: mostly connect-then-ready and embedded reset markers,
    // with stray bytes, flushes, lone connects and ignored codes mixed in
    task automatic random_phase();
        int base;
        base = items_sent;
        while (items_sent - base < PER_PHASE)
        begin
            case ($urandom_range(0, 15))
                0, 1:
                begin
                    send(REQ_CONNECT, 8'($urandom));
                    send_noise($urandom_range(0, 6));
                    send_marker(ready_pat, ready_len, $urandom_range(0, 3) == 0);
                end
                2, 3, 4, 5, 6, 7:
                begin
                    send_noise($urandom_range(0, 3));
                    send_marker(reset_pat, reset_len, $urandom_range(0, 3) == 0);
                end
                8, 9, 10, 11, 12: send(REQ_DATA, stream_byte());
                13:               send(REQ_FLUSH, 8'($urandom));
                14:               send(REQ_CONNECT, 8'($urandom));
                default:          send(REQ_UNUSED, 8'($urandom));
            endcase
        end
        // sometimes leave bytes held so the next settings see a stale hold
        if ($urandom_range(0, 1) != 0) send(REQ_FLUSH, 8'($urandom));
        drain();
    endtask

    initial
    begin
        int ph;
        items_sent = 0;
        burst_left = 1;
        rx_mode    = 0;
        rx_left    = 0;
        rx_tick    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ready marker 52 44, reset marker ff 00 ff
        load_markers(128'h4452, 2, 128'hFF00FF, 3);
        send(REQ_DATA, 8'h00);      // plain byte passes
        send(REQ_DATA, 8'hFF);      // held, may start the reset marker
        send(REQ_DATA, 8'h00);
        send(REQ_DATA, 8'hFF);      // full reset marker, event in its place
        send(REQ_DATA, 8'hFF);
        send(REQ_DATA, 8'h00);
        send(REQ_DATA, 8'h11);      // mismatch releases the held bytes
        send(REQ_DATA, 8'hFF);
        send(REQ_FLUSH, 8'h00);     // flush emits the held byte
        send(REQ_FLUSH, 8'hFF);     // flush with nothing held
        send(REQ_CONNECT, 8'h00);
        send(REQ_DATA, 8'h52);      // dropped while waiting for ready
        send(REQ_DATA, 8'h52);
        send(REQ_DATA, 8'h44);      // ready seen, nothing passes yet
        send(REQ_DATA, 8'hFF);      // held reset prefix
        send(REQ_CONNECT, 8'hFF);   // connect throws the hold away
        send(REQ_DATA, 8'h52);
        send(REQ_FLUSH, 8'h00);     // flush while waiting discards the hold
        send(REQ_UNUSED, 8'hA5);    // ignored code
        send(REQ_DATA, 8'hAA);
        drain();

        // directed: empty ready marker and reset detection off
        load_markers(128'h0, 0, 128'h0, 0);
        send(REQ_CONNECT, 8'h00);
        send(REQ_DATA, 8'h7E);      // first byte after connect passes at once
        send(REQ_DATA, 8'h80);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    // all-ones and all-zeros extremes, longest markers
                    palette[0] = 8'h00;
                    palette[1] = 8'hFF;
                    palette[2] = 8'h00;
                    palette[3] = 8'hFF;
                    load_markers({16{8'hFF}}, 16, {8{16'h00FF}}, 16);
                end
                1:       random_markers(0, 31);
                2:       random_markers(31, 0);
                3:       random_markers(1, 1);
                default: random_markers(pick_len(), pick_len());
            endcase
            random_phase();
        end

        drain();
        if (errors == 0 && results_due_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
